// File: rtl/llag_pkg.sv
// Shared types and constants for the life-like automaton grid.
// No dependencies; imported by every module of the block but llag_ram.
`timescale 1ns / 1ps

package llag_pkg;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_TOGGLE  = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [2:0] CFG_SURV_MIN  = 3'd0;
    localparam logic [2:0] CFG_SURV_MAX  = 3'd1;
    localparam logic [2:0] CFG_BIRTH_MIN = 3'd2;
    localparam logic [2:0] CFG_BIRTH_MAX = 3'd3;
    localparam logic [2:0] CFG_WRAP      = 3'd4;
    localparam logic [2:0] CFG_ROWS      = 3'd5;
    localparam logic [2:0] CFG_COLS      = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       value;
    } in_word_t;

    typedef struct packed {
        logic cell_value;
        logic coords_bad;
    } out_word_t;

    typedef struct packed {
        logic [3:0] surv_lo;
        logic [3:0] surv_hi;
        logic [3:0] born_lo;
        logic [3:0] born_hi;
        logic       wrap_edges;
        logic [6:0] rows_in_use;
        logic [6:0] cols_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CELL,
        ST_BAD,
        ST_ADV_FIRST,
        ST_ADV_LAST,
        ST_ADV_ROW,
        ST_ADV_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_CMD,
        RD_FIRST,
        RD_LAST,
        RD_ONE,
        RD_AHEAD
    } rd_sel_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_LOAD_FIRST,
        STEP_LOAD_ABOVE,
        STEP_ROW,
        STEP_CELL
    } step_t;

    typedef enum logic [1:0] {
        RES_CELL,
        RES_ZERO,
        RES_BAD
    } res_t;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        step_t   step;
        logic    out_load;
        res_t    res;
    } dp_cmd_t;

    typedef struct packed {
        logic is_adv;
        logic bad;
        logic last_row;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: rtl/llag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module llag_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/llag_datapath.sv
// Datapath: row memory, row registers, neighbor count lanes, result register.
// Depends on llag_pkg and llag_ram.
`timescale 1ns / 1ps

module llag_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  llag_pkg::cfg_t      cfg,
    input  llag_pkg::in_word_t  in_data,
    input  llag_pkg::dp_cmd_t   cmd,
    output llag_pkg::dp_stat_t  stat,
    input  logic                out_ready,
    output logic                out_valid,
    output llag_pkg::out_word_t out_data
);
    import llag_pkg::*;

    localparam int RW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    function automatic logic [MAX_COLS-1:0] left_nb(input logic [MAX_COLS-1:0] r,
                                                    input logic wrap,
                                                    input logic [CIW-1:0] last);
        logic [MAX_COLS-1:0] v;
        v = r << 1;
        v[0] = wrap & r[last];
        return v;
    endfunction

    function automatic logic [MAX_COLS-1:0] right_nb(input logic [MAX_COLS-1:0] r,
                                                     input logic wrap,
                                                     input logic [CIW-1:0] last);
        logic [MAX_COLS-1:0] v;
        v = r >> 1;
        v[last] = wrap & r[0];
        return v;
    endfunction

    function automatic logic rule(input logic [7:0] nb, input logic alive,
                                  input cfg_t c);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + {3'b000, nb[i]};
        end
        if (alive)
            return (c.surv_lo <= cnt) && (cnt <= c.surv_hi);
        else
            return (c.born_lo <= cnt) && (cnt <= c.born_hi);
    endfunction

    in_word_t            word_reg;
    logic [RCW-1:0]      cursor_reg, cursor_next;
    logic [MAX_COLS-1:0] prev_reg, prev_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [MAX_COLS-1:0] first_reg, first_next;
    logic [MAX_ROWS-1:0] valid_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    logic [RCW-1:0]      rows_eff;
    logic [CCW-1:0]      cols_eff;
    logic [CIW-1:0]      last_col;
    logic [MAX_COLS-1:0] rdata, rdata_eff, below, next_row;
    logic [MAX_COLS-1:0] al, ar, cl, cr, bl, br;
    logic [RW-1:0]       raddr, waddr;
    logic                we;
    logic [MAX_COLS-1:0] wdata, cell_row;
    logic [CIW-1:0]      bit_idx;
    logic                old_bit, new_bit;

    assign rows_eff = (cfg.rows_in_use == 7'd0) ? RCW'(1) :
                      (32'(cfg.rows_in_use) > MAX_ROWS) ? RCW'(MAX_ROWS) :
                      RCW'(cfg.rows_in_use);
    assign cols_eff = (cfg.cols_in_use == 7'd0) ? CCW'(1) :
                      (32'(cfg.cols_in_use) > MAX_COLS) ? CCW'(MAX_COLS) :
                      CCW'(cfg.cols_in_use);
    assign last_col = CIW'(cols_eff - CCW'(1));

    // rows never written since reset read as dead
    assign rdata_eff = rd_valid_reg ? rdata : '0;

    assign stat.is_adv   = (word_reg.cmd == CMD_ADVANCE);
    assign stat.bad      = (32'(word_reg.row) >= 32'(rows_eff)) ||
                           (32'(word_reg.col) >= 32'(cols_eff));
    assign stat.last_row = ((RCW+1)'(cursor_reg) + (RCW+1)'(1)) >= (RCW+1)'(rows_eff);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CMD:   raddr = RW'(word_reg.row);
            RD_FIRST: raddr = '0;
            RD_LAST:  raddr = RW'(rows_eff - RCW'(1));
            RD_ONE:   raddr = RW'(1);
            RD_AHEAD: raddr = RW'(cursor_reg + RCW'(2));
            default:  raddr = '0;
        endcase
    end

    // neighbor lanes, one per column
    assign below = stat.last_row ? (cfg.wrap_edges ? first_reg : '0) : rdata_eff;
    assign al = left_nb(prev_reg, cfg.wrap_edges, last_col);
    assign ar = right_nb(prev_reg, cfg.wrap_edges, last_col);
    assign cl = left_nb(cur_reg, cfg.wrap_edges, last_col);
    assign cr = right_nb(cur_reg, cfg.wrap_edges, last_col);
    assign bl = left_nb(below, cfg.wrap_edges, last_col);
    assign br = right_nb(below, cfg.wrap_edges, last_col);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            if (c < int'(cols_eff))
                next_row[c] = rule({al[c], prev_reg[c], ar[c], cl[c], cr[c],
                                    bl[c], below[c], br[c]}, cur_reg[c], cfg);
            else
                next_row[c] = cur_reg[c];
        end
    end

    assign bit_idx = CIW'(word_reg.col);
    assign old_bit = rdata_eff[bit_idx];

    always_comb
    begin
        unique case (word_reg.cmd)
            CMD_WRITE:  new_bit = word_reg.value;
            CMD_TOGGLE: new_bit = ~old_bit;
            default:    new_bit = old_bit;
        endcase
        cell_row = rdata_eff;
        cell_row[bit_idx] = new_bit;
    end

    assign we    = (cmd.step == STEP_ROW) || (cmd.step == STEP_CELL);
    assign waddr = (cmd.step == STEP_ROW) ? RW'(cursor_reg) : RW'(word_reg.row);
    assign wdata = (cmd.step == STEP_ROW) ? next_row : cell_row;

    llag_ram #(
        .WIDTH(MAX_COLS),
        .DEPTH(MAX_ROWS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        cursor_next = cursor_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        first_next  = first_reg;
        case (cmd.step)
            STEP_LOAD_FIRST:
            begin
                cur_next   = rdata_eff;
                first_next = rdata_eff;
            end
            STEP_LOAD_ABOVE:
            begin
                cursor_next = '0;
                if (!cfg.wrap_edges)
                    prev_next = '0;
                else if (rows_eff == RCW'(1))
                    prev_next = cur_reg;
                else
                    prev_next = rdata_eff;
            end
            STEP_ROW:
            begin
                cursor_next = cursor_reg + RCW'(1);
                prev_next   = cur_reg;
                cur_next    = rdata_eff;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[raddr];
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        if (cmd.latch_in)
            word_reg <= in_data;
        if (cmd.out_load)
        begin
            unique case (cmd.res)
                RES_CELL: out_data_reg <= '{cell_value: new_bit, coords_bad: 1'b0};
                RES_BAD:  out_data_reg <= '{cell_value: 1'b0, coords_bad: 1'b1};
                default:  out_data_reg <= '{cell_value: 1'b0, coords_bad: 1'b0};
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/llag_ctrl.sv
// Controller state machine: sequences cell commands and the row-by-row advance.
// Depends on llag_pkg.
`timescale 1ns / 1ps

module llag_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  llag_pkg::dp_stat_t stat,
    output llag_pkg::dp_cmd_t  cmd
);
    import llag_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.latch_in = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = RD_CMD;
        cmd.step     = STEP_NONE;
        cmd.out_load = 1'b0;
        cmd.res      = RES_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (stat.is_adv)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FIRST;
                    state_next = ST_ADV_FIRST;
                end
                else if (stat.bad)
                    state_next = ST_BAD;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CMD;
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                if (!stat.out_busy)
                begin
                    cmd.step     = STEP_CELL;
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_CELL;
                    state_next   = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_BAD;
                    state_next   = ST_IDLE;
                end
            end
            ST_ADV_FIRST:
            begin
                cmd.step   = STEP_LOAD_FIRST;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = ST_ADV_LAST;
            end
            ST_ADV_LAST:
            begin
                cmd.step   = STEP_LOAD_ABOVE;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ONE;
                state_next = ST_ADV_ROW;
            end
            ST_ADV_ROW:
            begin
                // row r written back while row r+2 is fetched
                cmd.step   = STEP_ROW;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AHEAD;
                if (stat.last_row)
                    state_next = ST_ADV_DONE;
            end
            ST_ADV_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_ZERO;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded while output word still held");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded next cycle");

    a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADV_ROW && stat.last_row) |=> (state_reg == ST_ADV_DONE))
        else $error("advance did not finish after last row");

    a_write_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_ROW || cmd.step == STEP_CELL) |->
        (state_reg == ST_ADV_ROW || state_reg == ST_CELL))
        else $error("row memory written outside a work state");

endmodule

// File: rtl/life_like_automaton_grid.sv
// Top level of the life-like automaton grid: configuration registers and glue.
// Depends on llag_pkg, llag_ctrl and llag_datapath.
`timescale 1ns / 1ps

// A grid of MAX_ROWS x MAX_COLS cells held one row per memory word. Every command
// returns one result word. Write, toggle and read go from accept through decode
// (row read) to write-back, which also loads the result. In an advance, after
// decoding and fetching the first and last rows, the rule is applied to one whole
// row per cycle, bounded by the single write port of the row memory, and a final
// state loads the result. The grid is dead after reset with no clearing pass:
// per-row valid flags mark rows never written. One command is worked at a time;
// the next is accepted while the previous result word still waits at the output.
module life_like_automaton_grid #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  llag_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output llag_pkg::out_word_t out_data,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [6:0]          cfg_wdata
);
    import llag_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surv_lo     <= 4'd2;
            cfg_reg.surv_hi     <= 4'd3;
            cfg_reg.born_lo     <= 4'd3;
            cfg_reg.born_hi     <= 4'd3;
            cfg_reg.wrap_edges  <= 1'b1;
            cfg_reg.rows_in_use <= 7'd64;
            cfg_reg.cols_in_use <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_SURV_MIN:  cfg_reg.surv_lo     <= cfg_wdata[3:0];
                CFG_SURV_MAX:  cfg_reg.surv_hi     <= cfg_wdata[3:0];
                CFG_BIRTH_MIN: cfg_reg.born_lo     <= cfg_wdata[3:0];
                CFG_BIRTH_MAX: cfg_reg.born_hi     <= cfg_wdata[3:0];
                CFG_WRAP:      cfg_reg.wrap_edges  <= cfg_wdata[0];
                CFG_ROWS:      cfg_reg.rows_in_use <= cfg_wdata;
                CFG_COLS:      cfg_reg.cols_in_use <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    llag_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    llag_datapath #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_data (out_data)
    );

endmodule

// File: bench/life_like_automaton_grid_tb.sv
// Self-checking bench for life_like_automaton_grid (depends on it and llag_pkg):
// random cell commands and generation steps, predicted by a behavioral grid model.
`timescale 1ns / 1ps

module life_like_automaton_grid_tb;
    import llag_pkg::*;

    localparam int NROW = 64;
    localparam int NCOL = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [6:0] cfg_wdata = '0;

    life_like_automaton_grid u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [NCOL-1:0] life_grid [NROW];
    logic [3:0] surv_lo, surv_hi, born_lo, born_hi;
    logic       wrap_on;
    logic [6:0] rows_cfg, cols_cfg;

    in_word_t  cmd_queue[$];
    out_word_t cell_results[$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        stim_done = 1'b0;
    bit        rx_hold = 1'b0;

    function automatic int clamp_dim(logic [6:0] v);
        if (v == 0) return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic int live_at(logic [NCOL-1:0] r, int c, int ncols, bit skip_mid);
        int n = 0;
        int x;
        for (int dc = -1; dc <= 1; dc++)
        begin
            x = c + dc;
            if (dc == 0 && skip_mid) continue;
            if (wrap_on) x = (x + ncols) % ncols;
            else if (x < 0 || x >= ncols) continue;
            n += r[x];
        end
        return n;
    endfunction

    function automatic void step_generation();
        int nr, nc, cnt;
        logic [NCOL-1:0] old_grid [NROW];
        logic [NCOL-1:0] nxt, up, dn;
        bit has_up, has_dn;
        nr = clamp_dim(rows_cfg);
        nc = clamp_dim(cols_cfg);
        old_grid = life_grid;
        for (int r = 0; r < nr; r++)
        begin
            has_up = (r > 0) || wrap_on;
            has_dn = (r + 1 < nr) || wrap_on;
            up = old_grid[(r + nr - 1) % nr];
            dn = old_grid[(r + 1) % nr];
            nxt = old_grid[r];
            for (int c = 0; c < nc; c++)
            begin
                cnt = live_at(old_grid[r], c, nc, 1'b1);
                if (has_up) cnt += live_at(up, c, nc, 1'b0);
                if (has_dn) cnt += live_at(dn, c, nc, 1'b0);
                if (old_grid[r][c]) nxt[c] = (surv_lo <= cnt) && (cnt <= surv_hi);
                else                nxt[c] = (born_lo <= cnt) && (cnt <= born_hi);
            end
            life_grid[r] = nxt;
        end
    endfunction

    function automatic out_word_t apply_command(in_word_t w);
        out_word_t res = '0;
        if (w.cmd == CMD_ADVANCE)
        begin
            step_generation();
            return res;
        end
        if (w.row >= clamp_dim(rows_cfg) || w.col >= clamp_dim(cols_cfg))
        begin
            res.coords_bad = 1'b1;
            return res;
        end
        if (w.cmd == CMD_WRITE) life_grid[w.row][w.col] = w.value;
        else if (w.cmd == CMD_TOGGLE) life_grid[w.row][w.col] = ~life_grid[w.row][w.col];
        res.cell_value = life_grid[w.row][w.col];
        return res;
    endfunction

    // driver
    int tx_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cell_results.push_back(apply_command(in_data));
            in_valid <= 1'b0;
            tx_gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) tx_gap = 0;
        end
        else if (!in_valid && rst_n && cmd_queue.size() > 0)
        begin
            if (tx_gap > 0) tx_gap--;
            else
            begin
                in_data  <= cmd_queue.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge clk)
    begin
        out_word_t exp_w;
        cycles++;
        if (out_valid && out_ready)
        begin
            if (cell_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %b", out_data);
            end
            else
            begin
                exp_w = cell_results.pop_front();
                if (exp_w.cell_value !== out_data.cell_value ||
                    exp_w.coords_bad !== out_data.coords_bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%b bad=%b got value=%b bad=%b",
                                 exp_w.cell_value, exp_w.coords_bad,
                                 out_data.cell_value, out_data.coords_bad);
                end
            end
            rx_gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) rx_gap = 0;
        end
        if (rx_hold) out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else out_ready <= 1'b1;
    end

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || in_valid || cell_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [6:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_SURV_MIN:  surv_lo  = v[3:0];
            CFG_SURV_MAX:  surv_hi  = v[3:0];
            CFG_BIRTH_MIN: born_lo  = v[3:0];
            CFG_BIRTH_MAX: born_hi  = v[3:0];
            CFG_WRAP:      wrap_on  = v[0];
            CFG_ROWS:      rows_cfg = v;
            CFG_COLS:      cols_cfg = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_rules(int slo, int shi, int blo, int bhi, bit wr, int nr, int nc);
        set_reg(CFG_SURV_MIN, 7'(slo));
        set_reg(CFG_SURV_MAX, 7'(shi));
        set_reg(CFG_BIRTH_MIN, 7'(blo));
        set_reg(CFG_BIRTH_MAX, 7'(bhi));
        set_reg(CFG_WRAP, 7'(wr));
        set_reg(CFG_ROWS, 7'(nr));
        set_reg(CFG_COLS, 7'(nc));
    endtask

    function automatic in_word_t make_cmd(logic [1:0] op, int r, int c, bit v);
        in_word_t w;
        w.cmd = op;
        w.row = 6'(r);
        w.col = 6'(c);
        w.value = v;
        return w;
    endfunction

    // mostly in-range coordinates, sometimes anywhere in the field
    task automatic queue_random(int n, int nr, int nc);
        int r, c, k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nr - 1);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nc - 1);
            if (k < 12) cmd_queue.push_back(make_cmd(CMD_ADVANCE, r, c, $urandom_range(0, 1)));
            else if (k < 50) cmd_queue.push_back(make_cmd(CMD_WRITE, r, c, $urandom_range(0, 1)));
            else if (k < 75) cmd_queue.push_back(make_cmd(CMD_TOGGLE, r, c, 1'b0));
            else cmd_queue.push_back(make_cmd(CMD_READ, r, c, $urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int nr, nc;
        foreach (life_grid[i]) life_grid[i] = '0;
        surv_lo = 4'd2; surv_hi = 4'd3; born_lo = 4'd3; born_hi = 4'd3;
        wrap_on = 1'b1; rows_cfg = 7'd64; cols_cfg = 7'd64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: glider-ish pattern on the default 64x64 grid and its corners
        cmd_queue.push_back(make_cmd(CMD_READ, 63, 63, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 0, 1, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 1, 2, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 2, 0, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 2, 1, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_TOGGLE, 2, 2, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_TOGGLE, 63, 63, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_ADVANCE, 63, 63, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_READ, 1, 0, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 0, 0, 1'b0));
        wait_drained();

        // bad coordinates on a small grid
        set_rules(2, 3, 3, 3, 1'b0, 5, 7);
        cmd_queue.push_back(make_cmd(CMD_WRITE, 5, 0, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_TOGGLE, 0, 7, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_READ, 63, 63, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 4, 6, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_READ, 4, 6, 1'b0));
        wait_drained();

        // receiver holds off while the sender keeps offering words
        rx_hold = 1'b1;
        queue_random(20, 5, 7);
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        wait_drained();

        // random phases over rule sets and sizes, extremes included
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph)
                0: set_rules(0, 8, 0, 8, 1'b1, 1, 1);
                1: set_rules(15, 15, 15, 15, 1'b1, 2, 2);
                2: set_rules(0, 0, 8, 8, 1'b0, 1, 64);
                3: set_rules(2, 3, 3, 3, 1'b1, 64, 1);
                4: set_rules(2, 3, 3, 3, 1'b1, 0, 0);
                5: set_rules(2, 3, 3, 3, 1'b0, 127, 100);
                6: set_rules(1, 5, 3, 6, 1'b1, 2, 33);
                7: set_rules(4, 9, 1, 2, 1'b0, 64, 64);
                default: set_rules($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 1), $urandom_range(1, 12),
                                   $urandom_range(1, 64));
            endcase
            nr = clamp_dim(rows_cfg);
            nc = clamp_dim(cols_cfg);
            queue_random(70, nr, nc);
            wait_drained();
        end
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (stim_done)
        begin
            if (mismatches == 0 && cell_results.size() == 0)
                $display("PASS life_like_automaton_grid");
            else
                $display("FAIL life_like_automaton_grid");
            $finish;
        end
        else if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL life_like_automaton_grid");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/llag_pkg.sv
rtl/llag_ram.sv
rtl/llag_datapath.sv
rtl/llag_ctrl.sv
rtl/life_like_automaton_grid.sv
bench/life_like_automaton_grid_tb.sv
